[hdl/first_fit_heap_allocator_assert.svh]
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define FFHA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FFHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFHA_ASSERT(lbl, clk, rst, prop, msg)
`define FFHA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hdl/ffha_pkg.sv]
`default_nettype none
package ffha_pkg;
   localparam int MAX_GRANULES_DEF = 4096;
   localparam int GRANULE_BYTES = 16;

   localparam logic [1:0] ACT_ALLOC   = 2'd0;
   localparam logic [1:0] ACT_FREE    = 2'd1;
   localparam logic [1:0] ACT_REALLOC = 2'd2;

   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_NO_ROOM = 2'd1;
   localparam logic [1:0] STAT_IGNORED = 2'd2;

   localparam logic [12:0] REG_MASK = 13'h1FFF;

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_CLEAR  = 14'b00000000000010,
      ST_LOC_CK = 14'b00000000000100,
      ST_WLK_RD = 14'b00000000001000,
      ST_WLK_CK = 14'b00000000010000,
      ST_SPL_T  = 14'b00000000100000,
      ST_SPL_G  = 14'b00000001000000,
      ST_FP_RD  = 14'b00000010000000,
      ST_FP_CK  = 14'b00000100000000,
      ST_FG_RD  = 14'b00001000000000,
      ST_FG_CK  = 14'b00010000000000,
      ST_FN_RD  = 14'b00100000000000,
      ST_FN_CK  = 14'b01000000000000,
      ST_FW     = 14'b10000000000000
   } state_type;
endpackage
`default_nettype wire

[hdl/ffha_ram.sv]
`default_nettype none
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

[hdl/first_fit_heap_allocator.sv]
// First-fit heap allocator over a heap of 16-byte granules. Block headers
// (start mark, used mark, length) live in one RAM with one entry per granule.
// Each request item yields one result item, unless the heap size register is
// written while it is in flight. An allocate walks the blocks from granule
// zero, reading and checking each visited block, then splits and writes back;
// a free checks the offset, walks the blocks below the freed one, then merges
// neighbors. A reallocate that moves does both. After reset, and after every
// write of the heap size register, a clearing pass runs through every entry of
// the header RAM, during which no request item is accepted.
`default_nettype none
module first_fit_heap_allocator
   import ffha_pkg::*;
#(
   parameter int MAX_GRANULES = MAX_GRANULES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // request_bytes [15:0], block_offset [31:16]
   input  wire logic [31:0] req_tdata,
   // action [1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // result_offset [15:0], copy_bytes [31:16], allocated_bytes [48:32],
   // used_blocks [61:49], zero fill [63:62]
   output logic      [63:0] rsp_tdata,
   // status [1:0], must_copy [2]
   output logic      [2:0]  rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   localparam int AW = $clog2(MAX_GRANULES);
   localparam int LW = $clog2(MAX_GRANULES + 1);
   localparam int CW = ((LW > 13) ? LW : 13) + 1;
   localparam int MW = LW + 2;
   localparam logic [CW-1:0] MAXC = CW'(MAX_GRANULES);

   state_type st_ff, st_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [CW-1:0] heap_ff, heap_in;
   logic [1:0]    act_ff, act_in;
   logic [CW-1:0] need_ff, need_in;
   logic [15:0]   off_ff, off_in;
   logic [CW-1:0] oldg_ff, oldg_in;
   logic [CW-1:0] g_ff, g_in;
   logic [CW-1:0] blk_len_ff, blk_len_in;
   logic          blk_used_ff, blk_used_in;
   logic          shrink_ff, shrink_in;
   logic          split_ff, split_in;
   logic [CW-1:0] p_ff, p_in;
   logic [CW-1:0] prev_ff, prev_in;
   logic          has_prev_ff, has_prev_in;
   logic          prev_used_ff, prev_used_in;
   logic [CW-1:0] prev_len_ff, prev_len_in;
   logic [CW-1:0] newg_ff, newg_in;
   logic [CW-1:0] newlen_ff, newlen_in;
   logic [CW-1:0] n_ff, n_in;
   logic [15:0]   res_ff, res_in;
   logic [15:0]   copy_ff, copy_in;
   logic [LW-1:0] total_ff, total_in;
   logic [LW-1:0] blocks_ff, blocks_in;
   logic          rv_ff, rv_in;
   logic [1:0]    rstat_ff, rstat_in;
   logic [15:0]   rres_ff, rres_in;
   logic          rmc_ff, rmc_in;
   logic [15:0]   rcopy_ff, rcopy_in;

   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [MW-1:0] wdata, rdata;
   logic          d_start, d_used;
   logic [CW-1:0] d_len;
   logic          cfg_wr;
   logic [12:0]   cfg_v;
   logic [CW-1:0] cfg_c;
   logic [CW-1:0] q, t, fin, sum;
   logic [15:0]   in_bytes, in_off;
   logic [31:0]   bytes_ext;

   ffha_ram #(.WIDTH(MW), .DEPTH(MAX_GRANULES)) u_hdr (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   assign d_start = rdata[MW-1];
   assign d_used  = rdata[MW-2];
   assign d_len   = CW'(rdata[LW-1:0]);

   assign csr_pready = 1'b1;
   assign csr_prdata = 32'(heap_ff);
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == 1'b0);
   assign cfg_v  = csr_pwdata[12:0] & REG_MASK;

   always_comb begin
      cfg_c = CW'(cfg_v);
      if (cfg_c < CW'(2)) begin
         cfg_c = CW'(2);
      end
      if (cfg_c > MAXC) begin
         cfg_c = MAXC;
      end
   end

   assign req_tready = (st_ff == ST_IDLE) && (!rv_ff || rsp_tready);
   assign in_bytes  = req_tdata[15:0];
   assign in_off    = req_tdata[31:16];
   assign bytes_ext = 32'(in_bytes) + 32'd31;

   assign rsp_tvalid = rv_ff;
   assign rsp_tuser  = {rmc_ff, rstat_ff};
   assign rsp_tdata  = {2'b00, 13'(blocks_ff), 17'(32'(total_ff) << 4), rcopy_ff, rres_ff};

   always_comb begin
      st_in = st_ff;
      clr_in = clr_ff;
      heap_in = heap_ff;
      act_in = act_ff;
      need_in = need_ff;
      off_in = off_ff;
      oldg_in = oldg_ff;
      g_in = g_ff;
      blk_len_in = blk_len_ff;
      blk_used_in = blk_used_ff;
      shrink_in = shrink_ff;
      split_in = split_ff;
      p_in = p_ff;
      prev_in = prev_ff;
      has_prev_in = has_prev_ff;
      prev_used_in = prev_used_ff;
      prev_len_in = prev_len_ff;
      newg_in = newg_ff;
      newlen_in = newlen_ff;
      n_in = n_ff;
      res_in = res_ff;
      copy_in = copy_ff;
      total_in = total_ff;
      blocks_in = blocks_ff;
      rv_in = rv_ff && !rsp_tready;
      rstat_in = rstat_ff;
      rres_in = rres_ff;
      rmc_in = rmc_ff;
      rcopy_in = rcopy_ff;
      we = 1'b0;
      waddr = '0;
      wdata = '0;
      raddr = '0;
      q = CW'(in_off[15:4]) - CW'(1);
      t = blk_len_ff;
      fin = blk_len_ff;
      sum = '0;

      case (st_ff)
         ST_CLEAR: begin
            we = 1'b1;
            waddr = clr_ff;
            if (clr_ff == '0) begin
               wdata = {1'b1, 1'b0, heap_ff[LW-1:0]};
               st_in = ST_IDLE;
            end else begin
               clr_in = clr_ff - AW'(1);
            end
         end
         ST_IDLE: begin
            raddr = q[AW-1:0];
            if (req_tvalid && req_tready) begin
               act_in = req_tuser;
               need_in = CW'(bytes_ext[31:4]);
               off_in = in_off;
               oldg_in = q;
               shrink_in = 1'b0;
               rstat_in = STAT_IGNORED;
               rres_in = '0;
               rmc_in = 1'b0;
               rcopy_in = '0;
               if (req_tuser == ACT_ALLOC) begin
                  g_in = '0;
                  st_in = ST_WLK_RD;
               end else if (req_tuser == ACT_FREE || req_tuser == ACT_REALLOC) begin
                  if (in_off[3:0] != 4'd0 || in_off < 16'd16 || q >= heap_ff || q >= MAXC) begin
                     rv_in = 1'b1;
                  end else begin
                     st_in = ST_LOC_CK;
                  end
               end else begin
                  rv_in = 1'b1;
               end
            end
         end
         ST_LOC_CK: begin
            p_in = '0;
            has_prev_in = 1'b0;
            shrink_in = 1'b0;
            if (!d_start) begin
               rv_in = 1'b1;
               st_in = ST_IDLE;
            end else if (act_ff == ACT_FREE) begin
               st_in = ST_FP_RD;
            end else begin
               copy_in = 16'(32'(d_len - CW'(1)) << 4);
               if (d_len >= need_ff) begin
                  shrink_in = 1'b1;
                  g_in = oldg_ff;
                  blk_len_in = d_len;
                  blk_used_in = d_used;
                  st_in = ST_SPL_T;
               end else begin
                  g_in = '0;
                  st_in = ST_WLK_RD;
               end
            end
         end
         ST_WLK_RD: begin
            raddr = g_ff[AW-1:0];
            if (g_ff < heap_ff && g_ff < MAXC) begin
               st_in = ST_WLK_CK;
            end else begin
               rstat_in = STAT_NO_ROOM;
               rv_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         ST_WLK_CK: begin
            if (d_len == '0) begin
               rstat_in = STAT_NO_ROOM;
               rv_in = 1'b1;
               st_in = ST_IDLE;
            end else if (!d_used && d_len >= need_ff) begin
               blk_len_in = d_len;
               blk_used_in = 1'b1;
               st_in = ST_SPL_T;
            end else begin
               g_in = g_ff + d_len;
               st_in = ST_WLK_RD;
            end
         end
         ST_SPL_T: begin
            t = g_ff + need_ff;
            split_in = (blk_len_ff - need_ff > CW'(2)) && (t < MAXC);
            if ((blk_len_ff - need_ff > CW'(2)) && (t < MAXC)) begin
               we = 1'b1;
               waddr = t[AW-1:0];
               wdata = {1'b1, 1'b0, LW'(blk_len_ff - need_ff)};
            end
            st_in = ST_SPL_G;
         end
         ST_SPL_G: begin
            fin = split_ff ? need_ff : blk_len_ff;
            we = 1'b1;
            waddr = g_ff[AW-1:0];
            wdata = {1'b1, blk_used_ff, LW'(fin)};
            if (shrink_ff) begin
               if (blk_used_ff) begin
                  total_in = total_ff - LW'(blk_len_ff - fin);
               end
               rstat_in = STAT_DONE;
               rres_in = off_ff;
               rv_in = 1'b1;
               st_in = ST_IDLE;
            end else begin
               total_in = total_ff + LW'(fin);
               blocks_in = blocks_ff + LW'(1);
               res_in = 16'(32'(g_ff + CW'(1)) << 4);
               if (act_ff == ACT_ALLOC) begin
                  rstat_in = STAT_DONE;
                  rres_in = 16'(32'(g_ff + CW'(1)) << 4);
                  rv_in = 1'b1;
                  st_in = ST_IDLE;
               end else begin
                  st_in = ST_FP_RD;
               end
            end
         end
         ST_FP_RD: begin
            raddr = p_ff[AW-1:0];
            if (p_ff < oldg_ff && p_ff < MAXC) begin
               st_in = ST_FP_CK;
            end else begin
               st_in = ST_FG_RD;
            end
         end
         ST_FP_CK: begin
            if (d_len == '0) begin
               st_in = ST_FG_RD;
            end else begin
               if (p_ff + d_len == oldg_ff) begin
                  prev_in = p_ff;
                  has_prev_in = 1'b1;
                  prev_used_in = d_used;
                  prev_len_in = d_len;
               end
               p_in = p_ff + d_len;
               st_in = ST_FP_RD;
            end
         end
         ST_FG_RD: begin
            raddr = oldg_ff[AW-1:0];
            st_in = ST_FG_CK;
         end
         ST_FG_CK: begin
            if (d_used) begin
               total_in = total_ff - LW'(d_len);
               blocks_in = blocks_ff - LW'(1);
            end
            we = 1'b1;
            waddr = oldg_ff[AW-1:0];
            if (has_prev_ff && !prev_used_ff) begin
               wdata = '0;
               newg_in = prev_ff;
               newlen_in = prev_len_ff + d_len;
            end else begin
               wdata = {1'b1, 1'b0, LW'(d_len)};
               newg_in = oldg_ff;
               newlen_in = d_len;
            end
            st_in = ST_FN_RD;
         end
         ST_FN_RD: begin
            sum = newg_ff + newlen_ff;
            n_in = sum;
            raddr = sum[AW-1:0];
            if (sum < heap_ff && sum < MAXC) begin
               st_in = ST_FN_CK;
            end else begin
               st_in = ST_FW;
            end
         end
         ST_FN_CK: begin
            if (d_start && !d_used) begin
               newlen_in = newlen_ff + d_len;
               we = 1'b1;
               waddr = n_ff[AW-1:0];
               wdata = '0;
            end
            st_in = ST_FW;
         end
         ST_FW: begin
            we = 1'b1;
            waddr = newg_ff[AW-1:0];
            wdata = {1'b1, 1'b0, LW'(newlen_ff)};
            rstat_in = STAT_DONE;
            if (act_ff == ACT_REALLOC) begin
               rres_in = res_ff;
               rmc_in = 1'b1;
               rcopy_in = copy_ff;
            end
            rv_in = 1'b1;
            st_in = ST_IDLE;
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      if (cfg_wr) begin
         heap_in = cfg_c;
         clr_in = AW'(MAX_GRANULES - 1);
         total_in = '0;
         blocks_in = '0;
         st_in = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLEAR;
         clr_ff <= AW'(MAX_GRANULES - 1);
         heap_ff <= MAXC;
         total_ff <= '0;
         blocks_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         clr_ff <= clr_in;
         heap_ff <= heap_in;
         total_ff <= total_in;
         blocks_ff <= blocks_in;
         rv_ff <= rv_in;
      end
      act_ff <= act_in;
      need_ff <= need_in;
      off_ff <= off_in;
      oldg_ff <= oldg_in;
      g_ff <= g_in;
      blk_len_ff <= blk_len_in;
      blk_used_ff <= blk_used_in;
      shrink_ff <= shrink_in;
      split_ff <= split_in;
      p_ff <= p_in;
      prev_ff <= prev_in;
      has_prev_ff <= has_prev_in;
      prev_used_ff <= prev_used_in;
      prev_len_ff <= prev_len_in;
      newg_ff <= newg_in;
      newlen_ff <= newlen_in;
      n_ff <= n_in;
      res_ff <= res_in;
      copy_ff <= copy_in;
      rstat_ff <= rstat_in;
      rres_ff <= rres_in;
      rmc_ff <= rmc_in;
      rcopy_ff <= rcopy_in;
   end

`include "first_fit_heap_allocator_assert.svh"
   `FFHA_ASSERT(a_accept_idle, clock, reset, (req_tvalid && req_tready) |-> (st_ff == ST_IDLE), "item accepted while busy")
   `FFHA_ASSERT(a_no_accept_clear, clock, reset, (st_ff == ST_CLEAR) |-> !req_tready, "ready during clearing pass")
   `FFHA_ASSERT(a_total_fits, clock, reset, (CW'(total_ff) <= heap_ff) && (blocks_ff <= total_ff), "used totals exceed heap")
   `FFHA_ASSERT(a_state_onehot, clock, reset, $onehot(st_ff), "state not one-hot")
endmodule
`default_nettype wire

[tb/first_fit_heap_allocator_checker.sv]
`timescale 1ns / 1ps
module first_fit_heap_allocator_checker
   import ffha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          failures,
   output int          pending
);
   localparam int HEAP_MAX = MAX_GRANULES_DEF;
   localparam logic [2:0] ADDR_HEAP_GRANULES = 3'd0;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] result_offset;
      logic        must_copy;
      logic [15:0] copy_bytes;
      logic [16:0] allocated_bytes;
      logic [12:0] used_blocks;
   } heap_outcome_type;

   bit          is_start [HEAP_MAX];
   bit          is_used [HEAP_MAX];
   int unsigned span [HEAP_MAX];
   int unsigned used_granules;
   int unsigned used_count;
   int unsigned heap_size;
   heap_outcome_type outcome_q [$];

   function automatic void heap_clear();
      for (int i = 0; i < HEAP_MAX; i++) begin
         is_start[i] = 0;
         is_used[i] = 0;
         span[i] = 0;
      end
      is_start[0] = 1;
      span[0] = heap_size;
      used_granules = 0;
      used_count = 0;
   endfunction

   function automatic bit offset_to_granule(int unsigned off, output int unsigned g);
      int unsigned q;
      g = 0;
      if ((off % 16) != 0 || off < 16) return 0;
      q = off / 16 - 1;
      if (q >= heap_size || q >= HEAP_MAX || !is_start[q]) return 0;
      g = q;
      return 1;
   endfunction

   function automatic void trim_block(int unsigned g, int unsigned need);
      int unsigned len;
      int unsigned t;
      len = span[g];
      if (len - need > 2) begin
         t = g + need;
         if (t >= HEAP_MAX) return;
         is_start[t] = 1;
         is_used[t] = 0;
         span[t] = len - need;
         span[g] = need;
      end
   endfunction

   function automatic bit take_first_fit(int unsigned need, output int unsigned found);
      int unsigned g;
      int unsigned len;
      g = 0;
      found = 0;
      while (g < heap_size && g < HEAP_MAX) begin
         len = span[g];
         if (len == 0) break;
         if (!is_used[g] && len >= need) begin
            trim_block(g, need);
            is_used[g] = 1;
            used_granules += span[g];
            used_count += 1;
            found = g;
            return 1;
         end
         g += len;
      end
      return 0;
   endfunction

   function automatic void release_block(int unsigned g);
      int unsigned p;
      int unsigned prev;
      int unsigned n;
      bit has_prev;
      p = 0;
      prev = 0;
      has_prev = 0;
      while (p < g && p < HEAP_MAX && span[p] != 0) begin
         if (p + span[p] == g) begin
            prev = p;
            has_prev = 1;
         end
         p += span[p];
      end
      if (is_used[g]) begin
         used_granules -= span[g];
         used_count -= 1;
         is_used[g] = 0;
      end
      if (has_prev && !is_used[prev]) begin
         span[prev] += span[g];
         is_start[g] = 0;
         span[g] = 0;
         g = prev;
      end
      n = g + span[g];
      if (n < heap_size && n < HEAP_MAX && is_start[n] && !is_used[n]) begin
         span[g] += span[n];
         is_start[n] = 0;
         span[n] = 0;
      end
   endfunction

   function automatic heap_outcome_type serve_request(logic [1:0] action, int unsigned bytes,
                                                      int unsigned off);
      heap_outcome_type r;
      int unsigned need;
      int unsigned g;
      int unsigned ng;
      int unsigned old;
      need = (bytes + 31) >> 4;
      r = '0;
      r.status = STAT_IGNORED;
      if (action == ACT_ALLOC) begin
         if (take_first_fit(need, ng)) begin
            r.status = STAT_DONE;
            r.result_offset = 16'((ng + 1) * GRANULE_BYTES);
         end else begin
            r.status = STAT_NO_ROOM;
         end
      end else if (action == ACT_FREE) begin
         if (offset_to_granule(off, g)) begin
            release_block(g);
            r.status = STAT_DONE;
         end
      end else if (action == ACT_REALLOC) begin
         if (offset_to_granule(off, g)) begin
            old = span[g];
            if (old >= need) begin
               trim_block(g, need);
               if (is_used[g]) used_granules -= old - span[g];
               r.status = STAT_DONE;
               r.result_offset = 16'(off);
            end else if (take_first_fit(need, ng)) begin
               r.copy_bytes = 16'((old - 1) * GRANULE_BYTES);
               release_block(g);
               r.status = STAT_DONE;
               r.must_copy = 1;
               r.result_offset = 16'((ng + 1) * GRANULE_BYTES);
            end else begin
               r.status = STAT_NO_ROOM;
            end
         end
      end
      r.allocated_bytes = 17'(used_granules * GRANULE_BYTES);
      r.used_blocks = 13'(used_count);
      return r;
   endfunction

   initial begin
      failures = 0;
      pending = 0;
      heap_size = HEAP_MAX;
      heap_clear();
   end

   always @(posedge clock) begin
      heap_outcome_type seen;
      heap_outcome_type want;
      int unsigned v;
      if (reset) begin
         heap_size = HEAP_MAX;
         heap_clear();
         outcome_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == ADDR_HEAP_GRANULES) begin
            v = csr_pwdata & REG_MASK;
            if (v < 2) v = 2;
            if (v > HEAP_MAX) v = HEAP_MAX;
            heap_size = v;
            heap_clear();
         end
         if (req_tvalid && req_tready)
            outcome_q.push_back(serve_request(req_tuser, req_tdata[15:0], req_tdata[31:16]));
         if (rsp_tvalid && rsp_tready) begin
            seen.status = rsp_tuser[1:0];
            seen.must_copy = rsp_tuser[2];
            seen.result_offset = rsp_tdata[15:0];
            seen.copy_bytes = rsp_tdata[31:16];
            seen.allocated_bytes = rsp_tdata[48:32];
            seen.used_blocks = rsp_tdata[61:49];
            if (outcome_q.size() == 0) begin
               failures++;
               $display("%0t: unexpected result item %h", $time, seen);
            end else begin
               want = outcome_q.pop_front();
               if (seen !== want) begin
                  failures++;
                  $display("%0t: mismatch expected status=%0d offset=%0d copy=%0b/%0d alloc=%0d used=%0d",
                           $time, want.status, want.result_offset, want.must_copy,
                           want.copy_bytes, want.allocated_bytes, want.used_blocks);
                  $display("%0t:          actual status=%0d offset=%0d copy=%0b/%0d alloc=%0d used=%0d",
                           $time, seen.status, seen.result_offset, seen.must_copy,
                           seen.copy_bytes, seen.allocated_bytes, seen.used_blocks);
               end
            end
         end
      end
      pending <= outcome_q.size();
   end
endmodule

[tb/tb_first_fit_heap_allocator.sv]
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator;
   import ffha_pkg::*;

   localparam int STALL_LIMIT = 100000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          failures;
   int          pending;
   bit          steady;
   bit          hold_wanted;
   int          quiet_cycles;
   logic [15:0] live_offsets [$];

   first_fit_heap_allocator dut (.*);

   first_fit_heap_allocator_checker checker_i (.*);

   initial clock = 0;
   always #10 clock = ~clock;

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         if (hold_wanted && hold_left == 0) begin
            hold_left = 400;
            hold_wanted = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 8);
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready && rsp_tuser[1:0] == STAT_DONE && rsp_tdata[15:0] != 0) begin
         live_offsets.push_back(rsp_tdata[15:0]);
         if (live_offsets.size() > 48) live_offsets.delete(0);
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("%0t: no progress, giving up", $time);
         $display("** first_fit_heap_allocator: FAILED **");
         $finish;
      end
   end

   task automatic send_request(logic [1:0] action, logic [15:0] bytes, logic [15:0] off);
      if (!steady && $urandom_range(0, 99) < 8) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= action;
      req_tdata <= {off, bytes};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_results();
      req_tvalid <= 0;
      @(negedge clock);
      wait (pending == 0);
      @(posedge clock);
   endtask

   task automatic write_heap_size(logic [31:0] value);
      drain_results();
      repeat (20) @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= 3'd0;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      live_offsets.delete();
   endtask

   function automatic logic [15:0] pick_bytes();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return 16'($urandom_range(0, 400));
      if (r < 95) return 16'($urandom_range(0, 4000));
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [15:0] pick_offset(bit take_out);
      int k;
      logic [15:0] off;
      if (live_offsets.size() == 0 || $urandom_range(0, 99) < 10)
         return 16'($urandom_range(0, 65535));
      k = $urandom_range(0, live_offsets.size() - 1);
      off = live_offsets[k];
      if (take_out) live_offsets.delete(k);
      return off;
   endfunction

   task automatic random_phase(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45)
            send_request(ACT_ALLOC, pick_bytes(), 16'($urandom_range(0, 65535)));
         else if (r < 75)
            send_request(ACT_FREE, 16'($urandom_range(0, 65535)), pick_offset(1));
         else if (r < 95)
            send_request(ACT_REALLOC, pick_bytes(), pick_offset(0));
         else
            send_request(2'd3, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
         if (i == count / 2 && count > 100) drain_results();
      end
   endtask

   initial begin
      reset = 1;
      steady = 0;
      hold_wanted = 0;
      quiet_cycles = 0;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = ACT_ALLOC;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (2) @(posedge clock);
      reset <= 0;

      send_request(ACT_ALLOC, 16'd0, 16'd0);
      send_request(ACT_ALLOC, 16'd1, 16'hFFFF);
      send_request(ACT_ALLOC, 16'd100, 16'd0);
      send_request(ACT_ALLOC, 16'hFFFF, 16'd0);
      send_request(ACT_FREE, 16'd0, 16'd8);
      send_request(ACT_FREE, 16'd0, 16'd0);
      send_request(ACT_FREE, 16'd0, 16'd48);
      send_request(ACT_FREE, 16'd0, 16'hFFF0);
      send_request(2'd3, 16'hFFFF, 16'd32);
      send_request(ACT_FREE, 16'd0, 16'd32);
      send_request(ACT_FREE, 16'd0, 16'd32);
      send_request(ACT_REALLOC, 16'd200, 16'd16);
      send_request(ACT_REALLOC, 16'd10, 16'd64);
      send_request(ACT_REALLOC, 16'd0, 16'd32);
      send_request(ACT_REALLOC, 16'hFFFF, 16'd64);
      send_request(ACT_REALLOC, 16'd5, 16'd24);
      send_request(ACT_ALLOC, 16'd65504, 16'd0);
      send_request(ACT_ALLOC, 16'd40000, 16'd0);
      send_request(ACT_REALLOC, 16'd60000, 16'd64);
      send_request(ACT_FREE, 16'd0, 16'd64);
      send_request(ACT_FREE, 16'd0, 16'd16);

      random_phase(230);
      write_heap_size(32'd64);
      random_phase(150);
      write_heap_size(32'd0);
      random_phase(40);
      write_heap_size(32'd8191);
      hold_wanted = 1;
      steady = 1;
      random_phase(200);
      steady = 0;
      write_heap_size(32'd2);
      random_phase(40);
      write_heap_size(32'd4096);
      random_phase(250);

      drain_results();
      repeat (30) @(posedge clock);
      if (failures == 0)
         $display("** first_fit_heap_allocator: PASSED **");
      else
         $display("** first_fit_heap_allocator: FAILED **");
      $finish;
   end
endmodule

[first_fit_heap_allocator.f]
+incdir+hdl
hdl/ffha_pkg.sv
hdl/ffha_ram.sv
hdl/first_fit_heap_allocator.sv
tb/first_fit_heap_allocator_checker.sv
tb/tb_first_fit_heap_allocator.sv
